[sv/cpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_pkg - shared types and constants of the circle pixel generator
// widths, command and register codes, walk constants and the point record
// ----------------------------------------------------------------------------
package cpg_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int STEP_W      = RADIUS_BITS + 1;
  localparam int COORD_W     = 16;
  localparam int COLOR_W     = 16;
  localparam int DEC_W       = 16;
  localparam int RADIUS_IN_W = 10;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  // decision start value and increments of the midpoint walk
  localparam logic [DEC_W-1:0] DEC_INIT    = DEC_W'(3);
  localparam logic [DEC_W-1:0] DEC_INC_OUT = DEC_W'(6);
  localparam logic [DEC_W-1:0] DEC_INC_IN  = DEC_W'(10);

  localparam logic [COORD_W-1:0] SCREEN_W_RST = COORD_W'(240);
  localparam logic [COORD_W-1:0] SCREEN_H_RST = COORD_W'(320);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  // mirror order: x offset sign/source, y offset sign/source
  typedef enum logic [2:0] {
    OCT_PX_PS = 3'd0,
    OCT_NX_PS = 3'd1,
    OCT_NS_PX = 3'd2,
    OCT_NS_NX = 3'd3,
    OCT_NX_NS = 3'd4,
    OCT_PX_NS = 3'd5,
    OCT_PS_NX = 3'd6,
    OCT_PS_PX = 3'd7
  } octant_t;

  typedef struct packed {
    logic [COORD_W-1:0]     col;
    logic [COORD_W-1:0]     row;
    logic [RADIUS_IN_W-1:0] radius;
    logic [COLOR_W-1:0]     color;
    logic                   filled;
  } circle_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } point_t;

endpackage

[sv/cpg_walk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpg_walk - midpoint circle walk
// holds the circle state, gives the current mirrored point and steps on advance
// ----------------------------------------------------------------------------
module cpg_walk (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic            advance,
  input  wire cpg_pkg::circle_t circle,
  output logic                 busy,
  output cpg_pkg::point_t      point
);
  import cpg_pkg::*;

  logic                active_r, active_nxt;
  logic [COORD_W-1:0]  col_r, col_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic                fill_r, fill_nxt;
  logic [STEP_W-1:0]   x_r, x_nxt;
  logic [STEP_W-1:0]   y_r, y_nxt;
  logic [DEC_W-1:0]    dec_r, dec_nxt;
  logic [STEP_W-1:0]   sweep_r, sweep_nxt;
  octant_t             oct_r, oct_nxt;

  logic [STEP_W-1:0]   s_cur;
  logic [COORD_W-1:0]  a_off, s_off;
  logic [STEP_W-1:0]   x_inc;
  logic [STEP_W-1:0]   y_walk;
  logic [DEC_W-1:0]    dec_walk;
  logic                dec_neg, y_zero, sweep_more, walk_done, oct_wrap;
  logic [STEP_W-1:0]   r_load;

  // offsets of the current point
  assign s_cur = fill_r ? sweep_r : y_r;
  assign a_off = COORD_W'(x_r);
  assign s_off = COORD_W'(s_cur);

  always_comb begin
    point.color = color_r;
    point.last  = oct_wrap && !sweep_more && walk_done;
    case (oct_r)
      OCT_PX_PS: begin point.x = col_r + a_off; point.y = row_r + s_off; end
      OCT_NX_PS: begin point.x = col_r - a_off; point.y = row_r + s_off; end
      OCT_NS_PX: begin point.x = col_r - s_off; point.y = row_r + a_off; end
      OCT_NS_NX: begin point.x = col_r - s_off; point.y = row_r - a_off; end
      OCT_NX_NS: begin point.x = col_r - a_off; point.y = row_r - s_off; end
      OCT_PX_NS: begin point.x = col_r + a_off; point.y = row_r - s_off; end
      OCT_PS_NX: begin point.x = col_r + s_off; point.y = row_r - a_off; end
      default:   begin point.x = col_r + s_off; point.y = row_r + a_off; end
    endcase
  end

  // one walk step: x first, then decision, then y
  assign x_inc      = x_r + STEP_W'(1);
  assign dec_neg    = dec_r[DEC_W-1];
  assign y_zero     = (y_r == '0);
  assign sweep_more = fill_r && (sweep_r < y_r);
  assign oct_wrap   = (oct_r == OCT_PS_PX);

  always_comb begin
    if (dec_neg) begin
      dec_walk = dec_r + (DEC_W'(x_inc) << 2) + DEC_INC_OUT;
      y_walk   = y_r;
    end else begin
      dec_walk = dec_r + DEC_INC_IN + (DEC_W'(x_inc) << 2) - (DEC_W'(y_r) << 2);
      y_walk   = y_zero ? '0 : y_r - STEP_W'(1);
    end
  end

  // y going below zero, or x passing y, ends the circle
  assign walk_done  = (!dec_neg && y_zero) || (x_inc > y_walk);
  assign busy       = active_r;
  assign r_load     = STEP_W'(circle.radius[RADIUS_IN_W-1:0]);

  always_comb begin
    active_nxt = active_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    color_nxt  = color_r;
    fill_nxt   = fill_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    sweep_nxt  = sweep_r;
    oct_nxt    = oct_r;
    if (load) begin
      active_nxt = 1'b1;
      col_nxt    = circle.col;
      row_nxt    = circle.row;
      color_nxt  = circle.color;
      fill_nxt   = circle.filled;
      x_nxt      = '0;
      y_nxt      = STEP_W'(r_load[RADIUS_BITS-1:0]);
      dec_nxt    = DEC_INIT - (DEC_W'(r_load[RADIUS_BITS-1:0]) << 1);
      sweep_nxt  = '0;
      oct_nxt    = OCT_PX_PS;
    end else if (advance) begin
      if (!oct_wrap) begin
        oct_nxt = octant_t'(oct_r + 3'd1);
      end else begin
        oct_nxt = OCT_PX_PS;
        if (sweep_more) begin
          sweep_nxt = sweep_r + STEP_W'(1);
        end else begin
          x_nxt     = x_inc;
          y_nxt     = y_walk;
          dec_nxt   = dec_walk;
          sweep_nxt = x_inc;
          if (walk_done) begin
            active_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      color_r  <= '0;
      fill_r   <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      dec_r    <= '0;
      sweep_r  <= '0;
      oct_r    <= OCT_PX_PS;
    end else begin
      active_r <= active_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      color_r  <= color_nxt;
      fill_r   <= fill_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      dec_r    <= dec_nxt;
      sweep_r  <= sweep_nxt;
      oct_r    <= oct_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_oct: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (oct_r == OCT_PX_PS))
    else $error("octant not at start while idle");

  a_x_le_y: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (x_r <= y_r))
    else $error("walk active with x past y");

  a_sweep_le_y: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && fill_r) |-> (sweep_r <= y_r))
    else $error("sweep index past y");

  a_fell_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> $past(advance && !load && point.last))
    else $error("walk ended without a last point");
`endif

endmodule
`default_nettype wire

[sv/circle_pixel_generator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_pixel_generator_core - midpoint circle pixel generator
// start transfers load a circle, next transfers give one clip-tested point each
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_*    | in        | tuser command, tdata circle (start) or ignored (next)
//  out_*   | out       | tdata point, color, on-screen flag; tlast on final point
//  cfg_*   | in        | screen width / height writes, no read-back
//
// one input transfer per cycle; a next transfer with a circle running gives
// its point on the output register in the next cycle
// the walk state advances in the same cycle, so transfers run back to back
// the input is held off only while the output register is full and stalled
// a start transfer or a next transfer with no circle running gives no result
// reset (synchronous, active low) clears the walk and sets the screen size
// ----------------------------------------------------------------------------
module circle_pixel_generator_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // circle input
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [15:0] center_x, [31:16] center_y, [41:32] radius, [57:42] pen_color,
  // [58] filled, [63:59] zero
  input  wire logic [cpg_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] command
  input  wire logic                           in_tuser,
  // pixel output
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color, [48] on_screen,
  // [55:49] zero
  output logic [cpg_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [cpg_pkg::COORD_W-1:0]    cfg_wdata
);
  import cpg_pkg::*;

  logic [COORD_W-1:0] scr_w_r, scr_w_nxt;
  logic [COORD_W-1:0] scr_h_r, scr_h_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_on_r;
  logic               out_last_r;

  logic     in_xfer;
  logic     start_xfer;
  logic     next_xfer;
  logic     busy;
  circle_t  circle;
  point_t   point;

  // screen size registers
  always_comb begin
    scr_w_nxt = scr_w_r;
    scr_h_nxt = scr_h_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  scr_w_nxt = cfg_wdata;
        REG_SCREEN_HEIGHT: scr_h_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // output register frees itself when taken, so input only waits on a stall
  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign start_xfer = in_xfer && (cmd_t'(in_tuser) == CMD_START);
  assign next_xfer  = in_xfer && (cmd_t'(in_tuser) == CMD_NEXT) && busy;

  // unpack the circle fields
  assign circle.col    = in_tdata[15:0];
  assign circle.row    = in_tdata[31:16];
  assign circle.radius = in_tdata[41:32];
  assign circle.color  = in_tdata[57:42];
  assign circle.filled = in_tdata[58];

  cpg_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (start_xfer),
    .advance (next_xfer),
    .circle  (circle),
    .busy    (busy),
    .point   (point)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (next_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r     <= SCREEN_W_RST;
      scr_h_r     <= SCREEN_H_RST;
      out_valid_r <= 1'b0;
    end else begin
      scr_w_r     <= scr_w_nxt;
      scr_h_r     <= scr_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, clip test against the current screen size
  always_ff @(posedge clk) begin
    if (next_xfer) begin
      out_x_r     <= point.x;
      out_y_r     <= point.y;
      out_color_r <= point.color;
      out_on_r    <= (point.x < scr_w_r) && (point.y < scr_h_r);
      out_last_r  <= point.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_on_r, out_color_r, out_y_r, out_x_r};

`ifndef NO_ASSERTIONS
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !next_xfer && out_tready) |=> !out_valid_r)
    else $error("result from a start or idle transfer");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    next_xfer |=> out_valid_r)
    else $error("next transfer lost its result");

  a_busy_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start_xfer))
    else $error("walk started without a start transfer");
`endif

endmodule
`default_nettype wire

[bench/circle_pixel_generator_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pixel_generator_core_test - self-checking bench of the circle walker
// drives start and next transfers, predicts every point of the midpoint walk
// (eight-way mirror order, outline and filled sweeps, 16-bit wrap, clipping
// against the screen registers, last flag) and compares each output transfer
// field by field, under random stalls on both sides and a long output hold
// ----------------------------------------------------------------------------
module circle_pixel_generator_core_test;
  import cpg_pkg::*;

  localparam int MAX_REPORTS = 50;

  // expected point as it leaves the block
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               on_screen;
    logic               last;
  } pixel_t;

  // every input has a known value from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  wire                   in_tready;
  // [15:0] center_x, [31:16] center_y, [41:32] radius, [57:42] pen_color,
  // [58] filled, [63:59] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // [0] command
  cmd_t                  in_tuser   = CMD_NEXT;
  wire                   out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color, [48] on_screen,
  // [55:49] zero
  wire [OUT_DATA_W-1:0]  out_tdata;
  wire                   out_tlast;
  logic                  cfg_we     = 1'b0;
  reg_idx_t              cfg_index  = REG_SCREEN_WIDTH;
  logic [COORD_W-1:0]    cfg_wdata  = '0;

  // bench copy of the screen registers and of the walk state
  logic [COORD_W-1:0] scr_w     = SCREEN_W_RST;
  logic [COORD_W-1:0] scr_h     = SCREEN_H_RST;
  logic               walking   = 1'b0;
  logic [COORD_W-1:0] ctr_col   = '0;
  logic [COORD_W-1:0] ctr_row   = '0;
  logic [COLOR_W-1:0] pen       = '0;
  logic               fill_disc = 1'b0;
  logic [STEP_W-1:0]  walk_x    = '0;
  logic [STEP_W-1:0]  walk_y    = '0;
  logic [STEP_W-1:0]  sweep     = '0;
  logic [DEC_W-1:0]   decision  = '0;
  octant_t            oct       = OCT_PX_PS;

  // points still owed by the block, oldest first
  pixel_t pending_pixels[$];

  // idle and stall rates in percent; the first phase applies from the start
  int send_idle_pct  = 27;
  int recv_stall_pct = 58;

  // long output hold: the test bumps hold_reqs, the ready process counts it out
  int hold_reqs = 0;
  int hold_len  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int items_sent     = 0;
  int idle_nexts     = 0;
  int pixels_checked = 0;
  int circles_done   = 0;
  int clipped        = 0;
  int mismatches     = 0;

  circle_pixel_generator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("%0t ns: timeout, %0d points still outstanding", $time, pending_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // walk predictor: applies one accepted transfer to the bench state and
  // queues the point it yields, if any
  // --------------------------------------------------------------------------
  task automatic predict_pixel(input cmd_t cmd, input circle_t c);
    logic [COORD_W-1:0] a16;
    logic [COORD_W-1:0] s16;
    logic [STEP_W-1:0]  xn;
    int                 yn;
    pixel_t             p;
    if (cmd == CMD_START) begin
      // a start always reloads, even over a circle still running
      ctr_col   = c.col;
      ctr_row   = c.row;
      pen       = c.color;
      fill_disc = c.filled;
      walk_x    = '0;
      walk_y    = STEP_W'(c.radius);
      sweep     = '0;
      decision  = DEC_INIT - DEC_W'(2 * c.radius);
      oct       = OCT_PX_PS;
      walking   = 1'b1;
    end else if (walking) begin
      a16 = COORD_W'(walk_x);
      // filled mode mirrors the sweep index in place of y
      s16 = COORD_W'(fill_disc ? sweep : walk_y);
      case (oct)
        OCT_PX_PS: begin p.x = ctr_col + a16; p.y = ctr_row + s16; end
        OCT_NX_PS: begin p.x = ctr_col - a16; p.y = ctr_row + s16; end
        OCT_NS_PX: begin p.x = ctr_col - s16; p.y = ctr_row + a16; end
        OCT_NS_NX: begin p.x = ctr_col - s16; p.y = ctr_row - a16; end
        OCT_NX_NS: begin p.x = ctr_col - a16; p.y = ctr_row - s16; end
        OCT_PX_NS: begin p.x = ctr_col + a16; p.y = ctr_row - s16; end
        OCT_PS_NX: begin p.x = ctr_col + s16; p.y = ctr_row - a16; end
        default: begin p.x = ctr_col + s16; p.y = ctr_row + a16; end
      endcase
      p.color     = pen;
      p.on_screen = (p.x < scr_w) && (p.y < scr_h);
      p.last      = 1'b0;
      if (oct != OCT_PS_PX) begin
        oct = octant_t'(oct + 3'd1);
      end else begin
        oct = OCT_PX_PS;
        if (fill_disc && sweep < walk_y) begin
          sweep = sweep + 1'b1;
        end else begin
          // x steps first, the decision update then sees the new x
          xn = walk_x + 1'b1;
          yn = int'(walk_y);
          if (decision[DEC_W-1]) begin
            decision = decision + DEC_W'(4 * xn) + DEC_INC_OUT;
          end else begin
            decision = decision + DEC_INC_IN + DEC_W'(4 * xn) - DEC_W'(4 * walk_y);
            yn = yn - 1;
          end
          if (yn < 0 || int'(xn) > yn) begin
            p.last  = 1'b1;
            walking = 1'b0;
          end
          walk_x = xn;
          walk_y = (yn < 0) ? '0 : STEP_W'(yn);
          sweep  = xn;
        end
      end
      pending_pixels.push_back(p);
    end
  endtask

  function automatic circle_t make_circle(input logic [COORD_W-1:0] col, row,
                                          input logic [RADIUS_IN_W-1:0] r,
                                          input logic [COLOR_W-1:0] color,
                                          input logic filled);
    circle_t c;
    c.col    = col;
    c.row    = row;
    c.radius = r;
    c.color  = color;
    c.filled = filled;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // one input transfer; returns at the accepting edge with tvalid still high
  // so that back-to-back items keep the line up
  // --------------------------------------------------------------------------
  task automatic send_item(input cmd_t cmd, input circle_t c);
    logic [IN_DATA_W-1:0] word;
    if (cmd == CMD_START) begin
      word = {5'b0, c.filled, c.color, c.radius, c.row, c.col};
    end else begin
      // payload is don't-care on a next request, so scramble it
      word = {5'b0, 27'($urandom), 32'($urandom)};
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= word;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (cmd == CMD_NEXT && !walking) idle_nexts++;
    else items_sent++;
    predict_pixel(cmd, c);
  endtask

  // request points until the walk reports its final one
  task automatic finish_circle();
    while (walking) send_item(CMD_NEXT, '0);
  endtask

  // drop tvalid, let every owed point come out, then let the output
  // register settle before returning
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called from an idle block, right after wait_idle
  task automatic set_screen(input logic [COORD_W-1:0] w, h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
  endtask

  // --------------------------------------------------------------------------
  // random circle: mostly whole walks with small radii, some cut short by a
  // new start (full 10-bit radius), a few stray next requests
  // --------------------------------------------------------------------------
  task automatic draw_random_circle();
    circle_t c;
    int      pick;
    pick     = $urandom_range(0, 99);
    c.col    = ($urandom_range(0, 9) < 7) ? COORD_W'($urandom_range(0, 300)) : COORD_W'($urandom);
    c.row    = ($urandom_range(0, 9) < 7) ? COORD_W'($urandom_range(0, 400)) : COORD_W'($urandom);
    c.color  = COLOR_W'($urandom);
    c.filled = ($urandom_range(0, 2) == 0);
    if (pick < 80) begin
      c.radius = c.filled ? RADIUS_IN_W'($urandom_range(0, 6))
                          : RADIUS_IN_W'($urandom_range(0, 24));
      send_item(CMD_START, c);
      finish_circle();
      // a request after the final point must stay silent
      if ($urandom_range(0, 4) == 0) send_item(CMD_NEXT, '0);
    end else if (pick < 95) begin
      c.radius = RADIUS_IN_W'($urandom);
      send_item(CMD_START, c);
      repeat ($urandom_range(0, 12)) send_item(CMD_NEXT, '0);
    end else begin
      send_item(CMD_NEXT, '0);
    end
  endtask

  task automatic run_random_circles(input int target);
    int first;
    first = items_sent;
    while (items_sent - first < target) draw_random_circle();
  endtask

  // ---------------------------------------------------------------- tests --

  // nothing loaded yet, so next requests give no point
  task automatic test_next_while_idle();
    send_item(CMD_NEXT, '0);
    send_item(CMD_NEXT, '0);
  endtask

  task automatic test_directed_circles();
    // radius zero: eight copies of the center, the last one flagged
    send_item(CMD_START, make_circle(16'd5, 16'd7, 10'd0, 16'h1234, 1'b0));
    finish_circle();
    // widest radius, filled, centered on the far corner: clips
    send_item(CMD_START, make_circle(16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF, 1'b1));
    send_item(CMD_NEXT, '0);
    send_item(CMD_NEXT, '0);
    // start over a running circle, radius one at the origin wraps below zero
    send_item(CMD_START, make_circle(16'd0, 16'd0, 10'd1, 16'h0000, 1'b0));
    finish_circle();
    send_item(CMD_NEXT, '0);
  endtask

  // zero size clips everything, full size clips only coordinate 0xFFFF
  task automatic test_screen_extremes();
    logic [COORD_W-1:0] widths[4];
    logic [COORD_W-1:0] heights[4];
    widths  = '{16'd0, 16'd1, 16'hFFFF, 16'd1};
    heights = '{16'd0, 16'd1, 16'hFFFF, 16'hFFFF};
    for (int i = 0; i < 4; i++) begin
      wait_idle();
      set_screen(widths[i], heights[i]);
      run_random_circles(40);
    end
  endtask

  task automatic test_random_phase(input int send_pct, recv_pct,
                                   input logic [COORD_W-1:0] w, h,
                                   input int target);
    wait_idle();
    set_screen(w, h);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    run_random_circles(target);
  endtask

  // output held off while the sender keeps offering: the block must fill
  // and hold its input without losing or repeating a point
  task automatic test_receiver_hold();
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 300;
    hold_reqs++;
    send_item(CMD_START, make_circle(16'd120, 16'd160, 10'd40, 16'hF81F, 1'b0));
    finish_circle();
  endtask

  // ------------------------------------------------------------- sequence --
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_next_while_idle();
    test_directed_circles();
    test_screen_extremes();
    test_random_phase(27, 58, 16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)), 500);
    test_random_phase(58, 27, 16'($urandom), 16'($urandom), 500);
    test_receiver_hold();
    test_random_phase(0, 0, SCREEN_W_RST, SCREEN_H_RST, 350);
    wait_idle();
    $display("covered %0d circle and point requests, %0d requests with no circle running",
             items_sent, idle_nexts);
    $display("checked %0d points: %0d complete circles, %0d clipped, %0d mismatches",
             pixels_checked, circles_done, clipped, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ------------------------------------------------------ output receiver --
  // random stalls, or a long hold-off once the test asks for one
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = hold_len;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string field_name,
                             input logic [COORD_W-1:0] want_v, got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t ns: point %0d %s expected %0h got %0h",
                 $time, pixels_checked, field_name, want_v, got_v);
      end
    end
  endtask

  // every output transfer is matched against the oldest owed point
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    pixel_t got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.x         = out_tdata[15:0];
      got.y         = out_tdata[31:16];
      got.color     = out_tdata[47:32];
      got.on_screen = out_tdata[48];
      got.last      = out_tlast;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t ns: expected no point, got x %0h y %0h", $time, got.x, got.y);
        end
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.x, got.x);
        check_field("pixel_y", want.y, got.y);
        check_field("pixel_color", want.color, got.color);
        check_field("on_screen", 16'(want.on_screen), 16'(got.on_screen));
        check_field("last_point", 16'(want.last), 16'(got.last));
      end
      pixels_checked++;
      if (got.last) circles_done++;
      if (!got.on_screen) clipped++;
    end
  end

endmodule

[circle_pixel_generator_core.f]
sv/cpg_pkg.sv
sv/cpg_walk.sv
sv/circle_pixel_generator_core.sv
bench/circle_pixel_generator_core_test.sv
